// ===== src/sitoa_pkg.sv =====
// Shared types, constants and the digit glyph function for the radix text converter.
package sitoa_pkg;

  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned CNT_W      = $clog2(VALUE_BITS);
  localparam int unsigned RADIX_W    = 5;
  localparam int unsigned DIGIT_W    = 4;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_A     = 7'h41;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [7:0]                   radix;
  } in_word_t;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [RADIX_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [DIGIT_W-1:0]    remainder;
  } div_rsp_t;

  function automatic logic [6:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [6:0] d7;
    d7 = {3'b000, d};
    if (d < 4'd10) begin
      return CH_ZERO + d7;
    end
    return CH_A + (d7 - 7'd10);
  endfunction

endpackage

// ===== src/sitoa_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle by a radix of 2..16.
module sitoa_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sitoa_pkg::div_req_t req_i,
  output sitoa_pkg::div_rsp_t rsp_o
);
  import sitoa_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [DIGIT_W-1:0]    rem_q, rem_d;
  logic [RADIX_W-1:0]    div_q, div_d;
  logic [RADIX_W-1:0]    trial;
  logic                  fits;

  assign trial = {rem_q, quo_q[VALUE_BITS-1]};
  assign fits  = trial >= div_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(VALUE_BITS - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      // remainder stays below the divisor, so four bits hold it
      rem_d = fits ? DIGIT_W'(trial - div_q) : trial[DIGIT_W-1:0];
      quo_d = {quo_q[VALUE_BITS-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== src/signed_integer_to_ascii_radix_unit.sv =====
// Top level: signed number to ASCII digits in a radix of 2..16, most significant first.
//
//   channel | direction | handshake            | word
//   in      | input     | in_valid_i/in_stall_o  | in_word_t  (value, radix)
//   out     | output    | out_valid_o/out_stall_i | out_word_t (character, last)
//
// Each digit takes one full pass through the single bit-serial divider, which yields the
// digit as its remainder; the characters are then loaded into the output register one by
// one, and zero skips the divider. One number is converted at a time and
// in_stall_o stays high until its last character is loaded into the output register.
// Reset clears the sequencer and the output valid; out_stall_i holds the output word.
module signed_integer_to_ascii_radix_unit #(
  parameter int unsigned DIGIT_SLOTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sitoa_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sitoa_pkg::out_word_t out_word_o
);
  import sitoa_pkg::*;

  localparam int unsigned IDX_W = $clog2(DIGIT_SLOTS);
  localparam int unsigned ND_W  = $clog2(DIGIT_SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                state_q;
  logic                  neg_q;
  logic [ND_W-1:0]       nd_q;
  logic [VALUE_BITS-1:0] mag_q;
  logic [RADIX_W-1:0]    radix_q;
  logic                  start_q;
  logic                  out_valid_q;
  out_word_t             out_word_q;
  logic [DIGIT_W-1:0]    digits_q [DIGIT_SLOTS];

  div_req_t              div_req;
  div_rsp_t              div_rsp;

  logic                  in_accept;
  logic                  out_load;
  logic [VALUE_BITS-1:0] in_bits;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;
  logic [RADIX_W-1:0]    in_radix;
  logic [IDX_W-1:0]      wr_idx;
  logic [IDX_W-1:0]      rd_idx;
  logic                  div_last;

  assign in_stall_o = state_q != ST_IDLE;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = !out_valid_q || !out_stall_i;

  assign in_bits = in_word_i.value;
  assign in_neg  = in_bits[VALUE_BITS-1];
  assign in_mag  = in_neg ? (~in_bits + 1'b1) : in_bits;

  always_comb begin
    if (in_word_i.radix > {3'b000, RADIX_MAX}) begin
      in_radix = RADIX_MAX;
    end else if (in_word_i.radix < {3'b000, RADIX_MIN}) begin
      in_radix = RADIX_MIN;
    end else begin
      in_radix = in_word_i.radix[RADIX_W-1:0];
    end
  end

  assign wr_idx   = nd_q[IDX_W-1:0];
  assign rd_idx   = IDX_W'(nd_q - 1'b1);
  // stop on a zero quotient or once the digit buffer is full
  assign div_last = (div_rsp.quotient == '0) || (nd_q == ND_W'(DIGIT_SLOTS - 1));

  assign div_req.start    = start_q;
  assign div_req.dividend = mag_q;
  assign div_req.divisor  = radix_q;

  sitoa_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      neg_q       <= 1'b0;
      nd_q        <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // kick the divider on a nonzero number and after every digit but the last
      start_q <= (state_q == ST_IDLE && in_accept && in_bits != '0) ||
                 (state_q == ST_DIV && div_rsp.done && !div_last);
      if (state_q == ST_EMIT && out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_bits == '0) begin
              neg_q   <= 1'b0;
              nd_q    <= ND_W'(1);
              state_q <= ST_EMIT;
            end else begin
              neg_q   <= in_neg;
              nd_q    <= '0;
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            nd_q <= nd_q + 1'b1;
            if (div_last) begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            if (neg_q) begin
              neg_q <= 1'b0;
            end else begin
              nd_q <= nd_q - 1'b1;
              if (nd_q == ND_W'(1)) begin
                state_q <= ST_IDLE;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload: magnitude, radix, digit buffer and output word
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mag_q   <= in_mag;
      radix_q <= in_radix;
      if (in_bits == '0) begin
        digits_q[0] <= '0;
      end
    end
    if (state_q == ST_DIV && div_rsp.done) begin
      mag_q            <= div_rsp.quotient;
      digits_q[wr_idx] <= div_rsp.remainder;
    end
    if (state_q == ST_EMIT && out_load) begin
      if (neg_q) begin
        out_word_q.character <= CH_MINUS;
        out_word_q.last      <= 1'b0;
      end else begin
        out_word_q.character <= digit_glyph(digits_q[rd_idx]);
        out_word_q.last      <= nd_q == ND_W'(1);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== bench/tb_signed_integer_to_ascii_radix_unit.sv =====
// Self-checking bench for the signed radix text converter: directed table, then random numbers.
`timescale 1ns / 1ps

module tb_signed_integer_to_ascii_radix_unit;
  import sitoa_pkg::*;

  localparam int CLOCK_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 100;
  localparam int CALM_AFTER   = 80;
  localparam int TEXT_CHARS   = 17;
  localparam logic [16*8-1:0] GLYPHS = "0123456789ABCDEF";

  // Nonzero text holds the expected characters, right-justified; zero defers to spell_number.
  typedef struct packed {
    logic [VALUE_BITS-1:0]   value;
    logic [7:0]              radix;
    logic [TEXT_CHARS*8-1:0] text;
  } directed_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  out_word_t     pending_chars [$];
  directed_row_t directed_plan [25];
  int            mismatches;
  int            cycle_count;
  int            stall_left;
  bit            calm;

  signed_integer_to_ascii_radix_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Expected characters of one number, most significant digit first.
  function automatic void spell_number(input in_word_t w);
    logic [VALUE_BITS-1:0] mag;
    int unsigned           base;
    int                    count;
    logic [3:0]            digits [VALUE_BITS];
    out_word_t             c;
    if (w.value == '0) begin
      c.character = CH_ZERO;
      c.last      = 1'b1;
      pending_chars.push_back(c);
      return;
    end
    if (w.radix > RADIX_MAX) base = int'(RADIX_MAX);
    else if (w.radix < RADIX_MIN) base = int'(RADIX_MIN);
    else base = int'(w.radix);
    mag = w.value;
    if (w.value[VALUE_BITS-1]) begin
      c.character = CH_MINUS;
      c.last      = 1'b0;
      pending_chars.push_back(c);
      mag = ~w.value + 1'b1;
    end
    count = 0;
    while (mag != '0 && count < VALUE_BITS) begin
      digits[count] = 4'(mag % base);
      mag = VALUE_BITS'(mag / base);
      count++;
    end
    for (int i = count - 1; i >= 0; i--) begin
      c.character = GLYPHS[(15 - int'(digits[i])) * 8 +: 7];
      c.last      = (i == 0);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic void enqueue_text(input logic [TEXT_CHARS*8-1:0] text);
    out_word_t c;
    for (int i = TEXT_CHARS - 1; i >= 0; i--) begin
      if (text[i*8 +: 8] != 8'h00) begin
        c.character = text[i*8 +: 7];
        c.last      = (i == 0);
        pending_chars.push_back(c);
      end
    end
  endfunction

  task automatic offer_number(input in_word_t w, input logic [TEXT_CHARS*8-1:0] text);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    if (text != '0) enqueue_text(text);
    else spell_number(w);
  endtask

  // Output backpressure in random bursts.
  always @(negedge clk_i) begin
    if (calm || !rst_ni) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        $display("%0t: word with nothing expected: character %h last %b",
                 $time, out_word_o.character, out_word_o.last);
      end else begin
        want = pending_chars.pop_front();
        if (out_word_o.character !== want.character) begin
          mismatches++;
          $display("%0t: character expected %h actual %h",
                   $time, want.character, out_word_o.character);
        end
        if (out_word_o.last !== want.last) begin
          mismatches++;
          $display("%0t: last expected %b actual %b", $time, want.last, out_word_o.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CLOCK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    in_word_t w;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    out_stall_i = 1'b0;
    mismatches  = 0;
    cycle_count = 0;
    stall_left  = 0;
    calm        = 1'b0;

    directed_plan = '{
      '{16'h0000, 8'd10,  "0"},
      '{16'h0000, 8'd0,   "0"},
      '{16'h0000, 8'd255, "0"},
      '{16'h8000, 8'd2,   "-1000000000000000"},
      '{16'h8000, 8'd16,  "-8000"},
      '{16'h7FFF, 8'd16,  "7FFF"},
      '{16'h7FFF, 8'd2,   "111111111111111"},
      '{16'hFFFF, 8'd0,   "-1"},
      '{16'hFFFF, 8'd1,   "-1"},
      '{16'h0001, 8'd2,   "1"},
      '{16'h00FF, 8'd255, "FF"},
      '{16'h00FF, 8'd17,  "FF"},
      '{16'h000F, 8'd16,  "F"},
      '{16'h000A, 8'd11,  "A"},
      '{16'h8001, 8'd10,  "-32767"},
      '{16'd12345, 8'd10, "12345"},
      '{16'd12345, 8'd7,  '0},
      '{-16'sd12345, 8'd3, '0},
      '{16'd1000, 8'd13,  '0},
      '{-16'sd100, 8'd9,  '0},
      '{16'h5A5A, 8'd5,   '0},
      '{16'hA5A5, 8'd12,  '0},
      '{16'h7FFE, 8'd15,  '0},
      '{-16'sd2, 8'd4,    '0},
      '{16'd16, 8'd14,    '0}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[i]) begin
      w.value = directed_plan[i].value;
      w.radix = directed_plan[i].radix;
      offer_number(w, directed_plan[i].text);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == CALM_AFTER) calm = 1'b1;
      case ($urandom_range(0, 4))
        0: w.value = VALUE_BITS'($urandom_range(0, 40) - 20);
        1: w.value = $urandom_range(0, 1) ? VALUE_BITS'(16'h8000 + $urandom_range(0, 3))
                                          : VALUE_BITS'(16'h7FFF - $urandom_range(0, 3));
        default: w.value = VALUE_BITS'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0: w.radix = 8'($urandom_range(0, 1));
        1: w.radix = 8'($urandom_range(17, 255));
        default: w.radix = 8'($urandom_range(2, 16));
      endcase
      offer_number(w, '0);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then watch for stray words.
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
